// ===== rtl/ipt_pkg.sv =====
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared constants, opcodes and status codes for the indexed priority table.
// ----------------------------------------------------------------------------
package ipt_pkg;

    localparam int CAPACITY = 64;
    localparam int ID_W     = $clog2(CAPACITY);
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int PRI_W    = 16;
    localparam int STAT_W   = 2;

    typedef logic [OP_W-1:0]   opcode_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [PRI_W-1:0]  pri_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam opcode_t OP_ADD     = 3'd0;
    localparam opcode_t OP_PROMOTE = 3'd1;
    localparam opcode_t OP_GET     = 3'd2;
    localparam opcode_t OP_GET_MAX = 3'd3;
    localparam opcode_t OP_POP_MAX = 3'd4;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_BAD_ID = 2'd1;
    localparam status_t ST_FULL   = 2'd2;
    localparam status_t ST_EMPTY  = 2'd3;

endpackage

// ===== rtl/ipt_channels.sv =====
// ----------------------------------------------------------------------------
// ipt channels
// Valid/ready channels for commands into and responses out of the table.
// ----------------------------------------------------------------------------
interface ipt_cmd_if;
    logic              valid;
    logic              ready;
    ipt_pkg::opcode_t  opcode;
    ipt_pkg::id_t      item_id;
    ipt_pkg::data_t    item_data;

    modport source (output valid, output opcode, output item_id, output item_data,
                    input ready);
    modport sink   (input valid, input opcode, input item_id, input item_data,
                    output ready);
endinterface

interface ipt_rsp_if;
    logic              valid;
    logic              ready;
    ipt_pkg::status_t  status;
    ipt_pkg::id_t      result_id;
    ipt_pkg::data_t    result_data;
    ipt_pkg::pri_t     result_priority;

    modport source (output valid, output status, output result_id, output result_data,
                    output result_priority, input ready);
    modport sink   (input valid, input status, input result_id, input result_data,
                    input result_priority, output ready);
endinterface

// ===== rtl/indexed_priority_table_core.sv =====
// Add and rejected commands are answered from decode; get and promote first read the entry
// in decode and answer from S_RESP; get max and pop max scan, drain and emit the maximum.
// One command is in flight at a time; the next is taken once the table is back in idle,
// even while the previous response still waits in the output register.
// The max search reads the entry memory once per entry through its single port.
// Reset clears all valid marks and the fresh id counter; memory contents are not cleared.
// ----------------------------------------------------------------------------
// indexed_priority_table_core
// Table of data/priority entries in one synchronous memory, with add, promote,
// get, get max and pop max commands and one response per command.
// ----------------------------------------------------------------------------
module indexed_priority_table_core (
    input  logic            clk,
    input  logic            rst_n,
    ipt_cmd_if.sink         cmd,
    ipt_rsp_if.source       rsp
);

    localparam int MEM_W   = ipt_pkg::DATA_W + ipt_pkg::PRI_W;
    localparam int FRESH_W = ipt_pkg::ID_W + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RESP   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    localparam ipt_pkg::id_t   LAST_ID  = ipt_pkg::id_t'(ipt_pkg::CAPACITY - 1);
    localparam logic [FRESH_W-1:0] FULL_CNT = FRESH_W'(ipt_pkg::CAPACITY);
    localparam ipt_pkg::pri_t  PRI_MAX  = '1;

    // control state
    logic [2:0]                    state_reg, state_next;
    logic [ipt_pkg::CAPACITY-1:0]  valid_reg, valid_next;
    logic [FRESH_W-1:0]            fresh_reg, fresh_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic                          best_found_reg, best_found_next;

    // payload
    ipt_pkg::opcode_t  op_reg;
    ipt_pkg::id_t      id_reg;
    ipt_pkg::data_t    data_reg;
    ipt_pkg::id_t      scan_reg, scan_next;
    ipt_pkg::id_t      cmp_id_reg, cmp_id_next;
    ipt_pkg::id_t      best_id_reg, best_id_next;
    ipt_pkg::data_t    best_data_reg, best_data_next;
    ipt_pkg::pri_t     best_pri_reg, best_pri_next;
    ipt_pkg::status_t  status_reg, status_next;
    ipt_pkg::id_t      res_id_reg, res_id_next;
    ipt_pkg::data_t    res_data_reg, res_data_next;
    ipt_pkg::pri_t     res_pri_reg, res_pri_next;

    // entry memory: {data, priority}
    logic [MEM_W-1:0]  mem [ipt_pkg::CAPACITY];
    logic [MEM_W-1:0]  mem_rd_reg;
    logic              mem_we, mem_re;
    ipt_pkg::id_t      mem_addr;
    logic [MEM_W-1:0]  mem_wd;

    ipt_pkg::data_t    rd_data;
    ipt_pkg::pri_t     rd_pri;
    ipt_pkg::pri_t     pri_inc;
    logic              slot_free;
    logic              cmd_xfer;

    assign rd_data   = mem_rd_reg[MEM_W-1:ipt_pkg::PRI_W];
    assign rd_pri    = mem_rd_reg[ipt_pkg::PRI_W-1:0];
    assign pri_inc   = (rd_pri == PRI_MAX) ? rd_pri : rd_pri + ipt_pkg::pri_t'(1);
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.result_id       = res_id_reg;
    assign rsp.result_data     = res_data_reg;
    assign rsp.result_priority = res_pri_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        fresh_next      = fresh_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        cmp_vld_next    = 1'b0;
        best_found_next = best_found_reg;
        scan_next       = scan_reg;
        cmp_id_next     = scan_reg;
        best_id_next    = best_id_reg;
        best_data_next  = best_data_reg;
        best_pri_next   = best_pri_reg;
        status_next     = status_reg;
        res_id_next     = res_id_reg;
        res_data_next   = res_data_reg;
        res_pri_next    = res_pri_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = id_reg;
        mem_wd          = {data_reg, ipt_pkg::pri_t'(0)};

        // fold the entry read in the previous cycle into the running maximum
        if (cmp_vld_reg && valid_reg[cmp_id_reg] && (!best_found_reg || rd_pri >= best_pri_reg))
        begin
            best_found_next = 1'b1;
            best_id_next    = cmp_id_reg;
            best_data_next  = rd_data;
            best_pri_next   = rd_pri;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (op_reg)
                    ipt_pkg::OP_ADD:
                    begin
                        if (slot_free)
                        begin
                            rsp_valid_next = 1'b1;
                            res_data_next  = '0;
                            res_pri_next   = '0;
                            state_next     = S_IDLE;
                            if (fresh_reg == FULL_CNT)
                            begin
                                status_next = ipt_pkg::ST_FULL;
                                res_id_next = '0;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_addr    = fresh_reg[ipt_pkg::ID_W-1:0];
                                valid_next[fresh_reg[ipt_pkg::ID_W-1:0]] = 1'b1;
                                fresh_next  = fresh_reg + FRESH_W'(1);
                                status_next = ipt_pkg::ST_OK;
                                res_id_next = fresh_reg[ipt_pkg::ID_W-1:0];
                            end
                        end
                    end
                    ipt_pkg::OP_PROMOTE, ipt_pkg::OP_GET:
                    begin
                        if (valid_reg[id_reg])
                        begin
                            mem_re     = 1'b1;
                            state_next = S_RESP;
                        end
                        else if (slot_free)
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = ipt_pkg::ST_BAD_ID;
                            res_id_next    = '0;
                            res_data_next  = '0;
                            res_pri_next   = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    ipt_pkg::OP_GET_MAX, ipt_pkg::OP_POP_MAX:
                    begin
                        if (|valid_reg)
                        begin
                            best_found_next = 1'b0;
                            scan_next       = '0;
                            state_next      = S_SCAN;
                        end
                        else if (slot_free)
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = ipt_pkg::ST_EMPTY;
                            res_id_next    = '0;
                            res_data_next  = '0;
                            res_pri_next   = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = ipt_pkg::ST_BAD_ID;
                            res_id_next    = '0;
                            res_data_next  = '0;
                            res_pri_next   = '0;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end
            S_RESP:
            begin
                // read data holds in mem_rd_reg until the response slot frees
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = ipt_pkg::ST_OK;
                    res_id_next    = id_reg;
                    res_data_next  = rd_data;
                    res_pri_next   = rd_pri;
                    state_next     = S_IDLE;
                    if (op_reg == ipt_pkg::OP_PROMOTE)
                    begin
                        mem_we       = 1'b1;
                        mem_wd       = {rd_data, pri_inc};
                        res_pri_next = pri_inc;
                    end
                end
            end
            S_SCAN:
            begin
                mem_re       = 1'b1;
                mem_addr     = scan_reg;
                cmp_vld_next = 1'b1;
                scan_next    = scan_reg + ipt_pkg::id_t'(1);
                if (scan_reg == LAST_ID)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = ipt_pkg::ST_OK;
                    res_id_next    = best_id_reg;
                    res_data_next  = best_data_reg;
                    res_pri_next   = best_pri_reg;
                    state_next     = S_IDLE;
                    if (op_reg == ipt_pkg::OP_POP_MAX)
                    begin
                        valid_next[best_id_reg] = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            fresh_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            fresh_reg      <= fresh_next;
            rsp_valid_reg  <= rsp_valid_next;
            cmp_vld_reg    <= cmp_vld_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            op_reg   <= cmd.opcode;
            id_reg   <= cmd.item_id;
            data_reg <= cmd.item_data;
        end
        scan_reg      <= scan_next;
        cmp_id_reg    <= cmp_id_next;
        best_id_reg   <= best_id_next;
        best_data_reg <= best_data_next;
        best_pri_reg  <= best_pri_next;
        status_reg    <= status_next;
        res_id_reg    <= res_id_next;
        res_data_reg  <= res_data_next;
        res_pri_reg   <= res_pri_next;
    end

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= FULL_CNT)
        else $error("fresh id counter beyond capacity");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("memory read and write in the same cycle");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (best_found_reg && valid_reg[best_id_reg]))
        else $error("selected maximum is not a valid entry");

    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("response raised without a command in progress");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> (state_reg == S_DECODE))
        else $error("command transfer did not start decode");

endmodule

// ===== tb/indexed_priority_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_priority_table_core_tb
// Drives add, promote, get, get max and pop max commands into the table with
// random gaps on both channels, predicts each response from a local copy of
// the table and compares every response field against that prediction.
// ----------------------------------------------------------------------------
module indexed_priority_table_core_tb;

    // Opcodes with no meaning; the block answers them as rejected commands
    localparam ipt_pkg::opcode_t OP_NONE_5 = 3'd5;
    localparam ipt_pkg::opcode_t OP_NONE_6 = 3'd6;
    localparam ipt_pkg::opcode_t OP_NONE_7 = 3'd7;

    localparam int RANDOM_COMMANDS = 1000;
    localparam int PROMOTE_RUN     = 120;
    localparam int IDLE_PERCENT    = 26;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES   = 80;

    typedef struct packed {
        ipt_pkg::status_t status;
        ipt_pkg::id_t     id;
        ipt_pkg::data_t   data;
        ipt_pkg::pri_t    pri;
    } response_t;

    class table_scoreboard;
        ipt_pkg::data_t entry_data [ipt_pkg::CAPACITY];
        ipt_pkg::pri_t  entry_pri  [ipt_pkg::CAPACITY];
        bit             entry_live [ipt_pkg::CAPACITY];
        int unsigned    fresh_ids;
        response_t      pending_responses [$];
        int unsigned    errors;
        int unsigned    status_seen [4];
        int unsigned    responses_seen;

        function new();
            fresh_ids      = 0;
            errors         = 0;
            responses_seen = 0;
            foreach (entry_live[i])
                entry_live[i] = 1'b0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        // Work out the response to one command and update the table copy
        function response_t predict_response(ipt_pkg::opcode_t op, ipt_pkg::id_t id,
                                             ipt_pkg::data_t data);
            response_t r;
            int        best;
            r    = '0;
            best = -1;
            case (op)
                ipt_pkg::OP_ADD:
                begin
                    if (fresh_ids >= ipt_pkg::CAPACITY)
                        r.status = ipt_pkg::ST_FULL;
                    else
                    begin
                        entry_data[fresh_ids] = data;
                        entry_pri[fresh_ids]  = '0;
                        entry_live[fresh_ids] = 1'b1;
                        r.status = ipt_pkg::ST_OK;
                        r.id     = ipt_pkg::id_t'(fresh_ids);
                        fresh_ids++;
                    end
                end
                ipt_pkg::OP_PROMOTE, ipt_pkg::OP_GET:
                begin
                    if (!entry_live[id])
                        r.status = ipt_pkg::ST_BAD_ID;
                    else
                    begin
                        // saturate at the top priority
                        if (op == ipt_pkg::OP_PROMOTE &&
                            entry_pri[id] != {ipt_pkg::PRI_W{1'b1}})
                            entry_pri[id] = entry_pri[id] + 1'b1;
                        r.status = ipt_pkg::ST_OK;
                        r.id     = id;
                        r.data   = entry_data[id];
                        r.pri    = entry_pri[id];
                    end
                end
                ipt_pkg::OP_GET_MAX, ipt_pkg::OP_POP_MAX:
                begin
                    // >= hands a tie to the higher id
                    for (int i = 0; i < ipt_pkg::CAPACITY; i++)
                        if (entry_live[i] && (best < 0 || entry_pri[i] >= entry_pri[best]))
                            best = i;
                    if (best < 0)
                        r.status = ipt_pkg::ST_EMPTY;
                    else
                    begin
                        r.status = ipt_pkg::ST_OK;
                        r.id     = ipt_pkg::id_t'(best);
                        r.data   = entry_data[best];
                        r.pri    = entry_pri[best];
                        if (op == ipt_pkg::OP_POP_MAX)
                            entry_live[best] = 1'b0;
                    end
                end
                default:
                    r.status = ipt_pkg::ST_BAD_ID;
            endcase
            return r;
        endfunction

        function void note_command(ipt_pkg::opcode_t op, ipt_pkg::id_t id,
                                   ipt_pkg::data_t data);
            pending_responses = {pending_responses, predict_response(op, id, data)};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_response(response_t got);
            response_t want;
            responses_seen++;
            status_seen[got.status]++;
            if (pending_responses.size() == 0)
            begin
                errors++;
                $display("%0t: response with none outstanding, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_responses.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("result_id", 32'(want.id), 32'(got.id));
            compare_field("result_data", 32'(want.data), 32'(got.data));
            compare_field("result_priority", 32'(want.pri), 32'(got.pri));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    bit   rx_hold_req;
    int   commands_sent;

    table_scoreboard sb = new();

    ipt_cmd_if cmd_ch ();
    ipt_rsp_if rsp_ch ();

    indexed_priority_table_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #25_000_000;
        $display("status: fail");
        $finish;
    end

    // Offer one command and hold it until the transfer completes
    task automatic send_command(ipt_pkg::opcode_t op, ipt_pkg::id_t id, ipt_pkg::data_t data);
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.opcode    <= op;
        cmd_ch.item_id   <= id;
        cmd_ch.item_data <= data;
        do
            @(posedge clk);
        while (!(cmd_ch.valid && cmd_ch.ready));
        sb.note_command(op, id, data);
        commands_sent++;
    endtask

    // Drop valid and wait for every outstanding response
    task automatic drain_responses();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (sb.pending_responses.size() != 0)
            @(negedge clk);
    endtask

    // Response side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response({rsp_ch.status, rsp_ch.result_id,
                                   rsp_ch.result_data, rsp_ch.result_priority});
        end
    end

    initial
    begin
        ipt_pkg::id_t     run_id;
        ipt_pkg::opcode_t op;
        ipt_pkg::id_t     id;
        ipt_pkg::data_t   data;
        int               r;

        rst_n            = 1'b0;
        calm             = 1'b0;
        rx_hold_req      = 1'b0;
        commands_sent    = 0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.opcode    = ipt_pkg::OP_ADD;
        cmd_ch.item_id   = '0;
        cmd_ch.item_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, ids never added, opcodes with no meaning
        send_command(ipt_pkg::OP_GET_MAX, '0, '0);
        send_command(ipt_pkg::OP_POP_MAX, '1, '1);
        send_command(ipt_pkg::OP_GET, '0, '0);
        send_command(ipt_pkg::OP_PROMOTE, '1, '0);
        send_command(OP_NONE_5, '0, '0);
        send_command(OP_NONE_6, '1, '1);
        send_command(OP_NONE_7, '0, '0);
        // fill a few entries, then ties, pop and reads of a popped entry
        send_command(ipt_pkg::OP_ADD, '1, '0);
        send_command(ipt_pkg::OP_ADD, '0, '1);
        send_command(ipt_pkg::OP_ADD, '0, 32'h5a5a_a5a5);
        send_command(ipt_pkg::OP_GET, 6'd0, '0);
        send_command(ipt_pkg::OP_GET, 6'd1, '0);
        send_command(ipt_pkg::OP_PROMOTE, 6'd1, '0);
        send_command(ipt_pkg::OP_PROMOTE, 6'd0, '0);
        send_command(ipt_pkg::OP_GET_MAX, '0, '0);
        send_command(ipt_pkg::OP_POP_MAX, '0, '0);
        send_command(ipt_pkg::OP_GET, 6'd1, '0);
        send_command(ipt_pkg::OP_PROMOTE, 6'd1, '0);
        send_command(ipt_pkg::OP_GET_MAX, '0, '0);
        send_command(ipt_pkg::OP_GET, '1, '0);

        // run one entry up a long ladder of promotes, back to back
        calm   = 1'b1;
        run_id = ipt_pkg::id_t'(sb.fresh_ids);
        send_command(ipt_pkg::OP_ADD, '0, $urandom);
        repeat (PROMOTE_RUN)
            send_command(ipt_pkg::OP_PROMOTE, run_id, $urandom);
        send_command(ipt_pkg::OP_GET, run_id, '0);
        send_command(ipt_pkg::OP_POP_MAX, '0, '0);
        calm = 1'b0;

        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            calm = (n >= 300 && n < 500);
            if (n == 100)
                rx_hold_req = 1'b1;
            if (n == 700)
                drain_responses();
            r = $urandom_range(99);
            if (r < 12)
                op = ipt_pkg::OP_ADD;
            else if (r < 47)
                op = ipt_pkg::OP_PROMOTE;
            else if (r < 67)
                op = ipt_pkg::OP_GET;
            else if (r < 90)
                op = ipt_pkg::OP_GET_MAX;
            else if (r < 97)
                op = ipt_pkg::OP_POP_MAX;
            else
                op = ipt_pkg::opcode_t'($urandom_range(OP_NONE_7, OP_NONE_5));
            // mostly aim at ids that have been handed out
            if (sb.fresh_ids > 0 && $urandom_range(99) < 75)
                id = ipt_pkg::id_t'($urandom_range(sb.fresh_ids - 1));
            else
                id = ipt_pkg::id_t'($urandom_range(ipt_pkg::CAPACITY - 1));
            r = $urandom_range(19);
            data = (r == 0) ? '0 : (r == 1) ? '1 : ipt_pkg::data_t'($urandom);
            send_command(op, id, data);
        end

        // make sure the table has been filled and an add refused
        while (sb.fresh_ids < ipt_pkg::CAPACITY)
            send_command(ipt_pkg::OP_ADD, '0, $urandom);
        send_command(ipt_pkg::OP_ADD, '0, $urandom);

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d commands, %0d responses: %0d ok, %0d invalid id, %0d full, %0d empty",
                 commands_sent, sb.responses_seen, sb.status_seen[ipt_pkg::ST_OK],
                 sb.status_seen[ipt_pkg::ST_BAD_ID], sb.status_seen[ipt_pkg::ST_FULL],
                 sb.status_seen[ipt_pkg::ST_EMPTY]);
        $display("one entry promoted %0d times in a row, all %0d ids handed out",
                 PROMOTE_RUN, ipt_pkg::CAPACITY);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ipt_pkg.sv
rtl/ipt_channels.sv
rtl/indexed_priority_table_core.sv
tb/indexed_priority_table_core_tb.sv
